// File: rtl/core/ler_pkg.sv
// package for the line echo responder: reply text table, command struct, sequencer states
// no dependencies
package ler_pkg;

  localparam int unsigned BufferSizeDefault = 32;

  localparam logic [7:0] CharCr = 8'h0d;
  localparam logic [7:0] CharLf = 8'h0a;

  // reply text: "RX: ", CR LF, then "ERR: input too long" CR LF
  localparam int unsigned TextLen  = 27;
  localparam int unsigned TextIdxW = 5;
  localparam logic [8*TextLen-1:0] TextRom = {
    "RX: ", CharCr, CharLf, "ERR: input too long", CharCr, CharLf
  };

  localparam logic [TextIdxW-1:0] TxtLead     = 5'd0;
  localparam logic [TextIdxW-1:0] TxtLeadLast = 5'd3;
  localparam logic [TextIdxW-1:0] TxtTail     = 5'd4;
  localparam logic [TextIdxW-1:0] TxtTailLast = 5'd5;
  localparam logic [TextIdxW-1:0] TxtErr      = 5'd6;
  localparam logic [TextIdxW-1:0] TxtErrLast  = 5'd26;

  typedef enum logic [2:0] {
    SeqIdle,
    SeqLead,
    SeqBody,
    SeqTail,
    SeqErr
  } ler_state_e;

  typedef struct packed {
    logic start;
    logic err;
  } ler_cmd_t;

  function automatic logic [7:0] text_char(input logic [TextIdxW-1:0] idx);
    logic [7:0] ch;
    ch = 8'h00;
    if (32'(idx) < TextLen) begin
      ch = TextRom[8*(TextLen-1-32'(idx)) +: 8];
    end
    return ch;
  endfunction

endpackage

// File: rtl/core/ler_store.sv
// line store memory, one write port and one registered read port
// depends on nothing but its parameters
module ler_store #(
  parameter int unsigned Depth = 31,
  parameter int unsigned AddrW = 5
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [7:0]       wr_data_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [7:0]       rd_data_o
);

  logic [7:0] mem [Depth];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: rtl/core/ler_seq.sv
// reply sequencer: text pointer and line store index step through text table and line
// store, one byte per cycle unless stalled; drives the output register; uses ler_pkg
module ler_seq import ler_pkg::*; #(
  parameter int unsigned LenW  = 5,
  parameter int unsigned AddrW = 5
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ler_cmd_t         cmd_i,
  input  logic [LenW-1:0]  len_i,
  input  logic [7:0]       rd_data_i,
  output logic [AddrW-1:0] rd_addr_o,
  output logic             busy_o,
  output logic             tx_valid_o,
  input  logic             tx_stall_i,
  output logic [7:0]       tx_data_o,
  output logic             reply_last_o
);

  ler_state_e           state_q, state_d;
  logic [TextIdxW-1:0]  ptr_q, ptr_d;
  logic [LenW-1:0]      idx_q, idx_d;
  logic [LenW-1:0]      len_q, len_d;
  logic                 out_valid_q, out_valid_d;
  logic [7:0]           out_data_q, out_data_d;
  logic                 out_last_q, out_last_d;
  logic                 load;
  logic                 body_last;
  logic [LenW-1:0]      rd_idx;
  logic [7:0]           next_char;
  logic                 next_last;

  assign load      = (!out_valid_q || !tx_stall_i) && (state_q != SeqIdle);
  assign body_last = (idx_q == len_q - LenW'(1));
  // prefetch the next body byte so that registered read data is ready in time
  assign rd_idx    = (state_q == SeqBody && load && !body_last) ? idx_q + LenW'(1) : idx_q;
  assign rd_addr_o = rd_idx[AddrW-1:0];

  always_comb begin
    state_d   = state_q;
    ptr_d     = ptr_q;
    idx_d     = idx_q;
    len_d     = len_q;
    next_char = text_char(ptr_q);
    next_last = 1'b0;
    unique case (state_q)
      SeqIdle: begin
        if (cmd_i.start) begin
          state_d = cmd_i.err ? SeqErr : SeqLead;
          ptr_d   = cmd_i.err ? TxtErr : TxtLead;
          idx_d   = '0;
          len_d   = len_i;
        end
      end
      SeqLead: begin
        if (load) begin
          if (ptr_q == TxtLeadLast) begin
            state_d = SeqBody;
          end else begin
            ptr_d = ptr_q + TextIdxW'(1);
          end
        end
      end
      SeqBody: begin
        next_char = rd_data_i;
        if (load) begin
          if (body_last) begin
            state_d = SeqTail;
            ptr_d   = TxtTail;
          end else begin
            idx_d = idx_q + LenW'(1);
          end
        end
      end
      SeqTail: begin
        next_last = (ptr_q == TxtTailLast);
        if (load) begin
          if (next_last) begin
            state_d = SeqIdle;
          end else begin
            ptr_d = ptr_q + TextIdxW'(1);
          end
        end
      end
      SeqErr: begin
        next_last = (ptr_q == TxtErrLast);
        if (load) begin
          if (next_last) begin
            state_d = SeqIdle;
          end else begin
            ptr_d = ptr_q + TextIdxW'(1);
          end
        end
      end
      default: begin
        state_d = SeqIdle;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    if (load) begin
      out_valid_d = 1'b1;
      out_data_d  = next_char;
      out_last_d  = next_last;
    end else if (!tx_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SeqIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q      <= ptr_d;
    idx_q      <= idx_d;
    len_q      <= len_d;
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
  end

  assign busy_o       = (state_q != SeqIdle);
  assign tx_valid_o   = out_valid_q;
  assign tx_data_o    = out_data_q;
  assign reply_last_o = out_last_q;

endmodule

// File: rtl/core/line_echo_responder.sv
// line echo responder top: line intake, line store and reply sequencer
// uses ler_pkg, ler_store, ler_seq
//
// usage:
//   rx channel (rx_valid_i, rx_stall_o, rx_data_i) takes one received byte per
//   transaction. bytes are stored until CR or LF; a terminator on an empty line
//   with no overflow is dropped. a byte beyond BUFFER_SIZE-1 stored bytes sets
//   the overflow flag and later bytes up to the line end are dropped.
//   tx channel (tx_valid_o, tx_stall_i, tx_data_o, reply_last_o) carries the
//   reply: "RX: " + line + CR LF, or "ERR: input too long" CR LF after an
//   overflow; reply_last_o marks the final byte.
// timing:
//   on a line end the sequencer state register leaves idle, then the output
//   register loads the first reply byte; after that one byte per cycle while
//   tx_stall_i is low, from a text pointer and a line store index stepping
//   through the text table and the line store. rx_stall_o is high while the
//   reply is being loaded. a stalled receiver holds the output register and
//   freezes the sequencer, stretching the reply.
// reset:
//   clears line length, overflow flag, sequencer and output valid; store
//   contents are not cleared and need no clearing pass.
module line_echo_responder import ler_pkg::*; #(
  parameter int unsigned BUFFER_SIZE = BufferSizeDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       rx_valid_i,
  output logic       rx_stall_o,
  input  logic [7:0] rx_data_i,
  output logic       tx_valid_o,
  input  logic       tx_stall_i,
  output logic [7:0] tx_data_o,
  output logic       reply_last_o
);

  localparam int unsigned Depth = BUFFER_SIZE - 1;
  localparam int unsigned LenW  = $clog2(BUFFER_SIZE);
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [LenW-1:0]  len_q, len_d;
  logic             ovf_q, ovf_d;
  logic             accept;
  logic             is_term;
  logic             wr_en;
  logic             busy;
  logic [AddrW-1:0] rd_addr;
  logic [7:0]       rd_data;
  ler_cmd_t         cmd;

  assign rx_stall_o = busy;
  assign accept     = rx_valid_i && !busy;
  assign is_term    = (rx_data_i == CharCr) || (rx_data_i == CharLf);

  always_comb begin
    len_d     = len_q;
    ovf_d     = ovf_q;
    wr_en     = 1'b0;
    cmd.start = 1'b0;
    cmd.err   = ovf_q;
    if (accept) begin
      if (is_term) begin
        if (len_q != '0 || ovf_q) begin
          cmd.start = 1'b1;
          len_d     = '0;
          ovf_d     = 1'b0;
        end
      end else if (!ovf_q) begin
        if (32'(len_q) < Depth) begin
          wr_en = 1'b1;
          len_d = len_q + LenW'(1);
        end else begin
          ovf_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      len_q <= len_d;
      ovf_q <= ovf_d;
    end
  end

  ler_store #(
    .Depth(Depth),
    .AddrW(AddrW)
  ) u_store (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(len_q[AddrW-1:0]),
    .wr_data_i(rx_data_i),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  ler_seq #(
    .LenW (LenW),
    .AddrW(AddrW)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .len_i       (len_q),
    .rd_data_i   (rd_data),
    .rd_addr_o   (rd_addr),
    .busy_o      (busy),
    .tx_valid_o  (tx_valid_o),
    .tx_stall_i  (tx_stall_i),
    .tx_data_o   (tx_data_o),
    .reply_last_o(reply_last_o)
  );

endmodule
